// File: sv/tss_pkg.sv
// Shared widths, codes and the step entry layout for the tone sweep step sequencer.
// No dependencies.
`default_nettype none

package tss_pkg;

    localparam int QUEUE_DEPTH = 16;
    localparam int ADDR_W      = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
    localparam int CNT_W       = $clog2(QUEUE_DEPTH + 1);

    localparam int FREQ_W = 15;
    localparam int DUR_W  = 16;
    localparam int TIME_W = 32;
    localparam int PROD_W = FREQ_W + DUR_W;

    localparam int S_TDATA_W = 80;
    localparam int M_TDATA_W = 24;

    localparam logic [1:0] REQ_UPDATE = 2'd0;
    localparam logic [1:0] REQ_ADD    = 2'd1;
    localparam logic [1:0] REQ_CLEAR  = 2'd2;

    localparam logic [1:0] DRV_NONE    = 2'd0;
    localparam logic [1:0] DRV_TONE    = 2'd1;
    localparam logic [1:0] DRV_SILENCE = 2'd2;

    typedef struct packed {
        logic [DUR_W-1:0]  duration_ms;
        logic [FREQ_W-1:0] end_freq;
        logic [FREQ_W-1:0] start_freq;
    } step_t;

    localparam int STEP_W = $bits(step_t);

endpackage

`default_nettype wire

// File: sv/tss_ram.sv
// Generic single-port-write, single-port-read RAM with registered read data.
// No dependencies.
`default_nettype none

module tss_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16
) (
    input  wire logic                                            aclk,
    input  wire logic                                            we,
    input  wire logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0]    waddr,
    input  wire logic [WIDTH-1:0]                                wdata,
    input  wire logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0]    raddr,
    output logic      [WIDTH-1:0]                                rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge aclk) begin
        if (we) begin
            mem[waddr] <= wdata;
        end
        rdata <= mem[raddr];
    end

endmodule

`default_nettype wire

// File: sv/tone_sweep_step_sequencer.sv
// Tone sweep step sequencer top level: step queue in RAM, control sequencer,
// shared multiply and restoring divider. Depends on tss_pkg and tss_ram.
//
//   port group  dir  tdata (low bit up)                                  tuser
//   s_*         in   now_ms[31:0] start_freq end_freq duration_ms, pad   req_type
//   m_*         out  tone_freq accepted busy_res, pad                    drive_action
//
// One word in flight at a time. Add, clear and idle update go straight to the result.
// Update that reads a step without sweeping: queue RAM read, then result.
// Sweep update: RAM read, multiply, 15-step divider, result.
// aresetn is synchronous; queue contents are not cleared, only the counts and control state.
// A stalled result holds in the output register; the next word is taken meanwhile.
`default_nettype none

module tone_sweep_step_sequencer
    import tss_pkg::*;
(
    input  wire logic                  aclk,
    input  wire logic                  aresetn,
    input  wire logic                  s_tvalid,
    output logic                       s_tready,
    input  wire logic [S_TDATA_W-1:0]  s_tdata,   // now_ms, start_freq, end_freq, duration_ms
    input  wire logic [1:0]            s_tuser,   // req_type
    output logic                       m_tvalid,
    input  wire logic                  m_tready,
    output logic      [M_TDATA_W-1:0]  m_tdata,   // tone_freq, accepted, busy_res
    output logic      [1:0]            m_tuser    // drive_action
);

    localparam logic [2:0] ST_IDLE = 3'd0;
    localparam logic [2:0] ST_READ = 3'd1;
    localparam logic [2:0] ST_MUL  = 3'd2;
    localparam logic [2:0] ST_DIV  = 3'd3;
    localparam logic [2:0] ST_OUT  = 3'd4;

    logic [2:0]        state_reg, state_next;
    logic [CNT_W-1:0]  step_count_reg, step_count_next;
    logic [CNT_W-1:0]  play_index_reg, play_index_next;
    logic              started_reg, started_next;
    logic [TIME_W-1:0] start_time_reg, start_time_next;
    logic [TIME_W-1:0] now_reg, now_next;

    logic [1:0]        res_drive_reg, res_drive_next;
    logic [FREQ_W-1:0] res_freq_reg, res_freq_next;
    logic              res_acc_reg, res_acc_next;

    logic [FREQ_W-1:0] base_reg, base_next;
    logic [FREQ_W-1:0] span_reg, span_next;
    logic              up_reg, up_next;
    logic [DUR_W-1:0]  elapsed_reg, elapsed_next;
    logic [DUR_W-1:0]  dur_reg, dur_next;
    logic [DUR_W-1:0]  rem_reg, rem_next;
    logic [FREQ_W-1:0] lo_reg, lo_next;
    logic [FREQ_W-1:0] quo_reg, quo_next;
    logic [3:0]        bit_cnt_reg, bit_cnt_next;

    logic                 m_tvalid_reg, m_tvalid_next;
    logic [M_TDATA_W-1:0] m_tdata_reg, m_tdata_next;
    logic [1:0]           m_tuser_reg, m_tuser_next;

    logic [1:0]        in_req;
    logic [TIME_W-1:0] in_now;
    step_t             in_step;
    step_t             rd_step;
    logic              ram_we;

    logic [TIME_W-1:0] elapsed;
    logic [PROD_W-1:0] product;
    logic [DUR_W:0]    trial;
    logic              trial_ge;
    logic              out_free;

    assign in_req                = s_tuser;
    assign in_now                = s_tdata[TIME_W-1:0];
    assign in_step.start_freq    = s_tdata[TIME_W +: FREQ_W];
    assign in_step.end_freq      = s_tdata[TIME_W+FREQ_W +: FREQ_W];
    assign in_step.duration_ms   = s_tdata[TIME_W+2*FREQ_W +: DUR_W];

    assign s_tready = (state_reg == ST_IDLE);
    assign ram_we   = s_tvalid && s_tready && (in_req == REQ_ADD)
                      && (step_count_reg < CNT_W'(QUEUE_DEPTH));

    tss_ram #(
        .WIDTH(STEP_W),
        .DEPTH(QUEUE_DEPTH)
    ) u_step_ram (
        .aclk  (aclk),
        .we    (ram_we),
        .waddr (step_count_reg[ADDR_W-1:0]),
        .wdata (in_step),
        .raddr (play_index_reg[ADDR_W-1:0]),
        .rdata (rd_step)
    );

    assign elapsed  = now_reg - start_time_reg;
    assign product  = PROD_W'(span_reg) * PROD_W'(elapsed_reg);
    assign trial    = {rem_reg, lo_reg[FREQ_W-1]};
    assign trial_ge = (trial >= {1'b0, dur_reg});
    assign out_free = !m_tvalid_reg || m_tready;

    always_comb begin
        state_next      = state_reg;
        step_count_next = step_count_reg;
        play_index_next = play_index_reg;
        started_next    = started_reg;
        start_time_next = start_time_reg;
        now_next        = now_reg;
        res_drive_next  = res_drive_reg;
        res_freq_next   = res_freq_reg;
        res_acc_next    = res_acc_reg;
        base_next       = base_reg;
        span_next       = span_reg;
        up_next         = up_reg;
        elapsed_next    = elapsed_reg;
        dur_next        = dur_reg;
        rem_next        = rem_reg;
        lo_next         = lo_reg;
        quo_next        = quo_reg;
        bit_cnt_next    = bit_cnt_reg;
        m_tvalid_next   = m_tvalid_reg && !m_tready;
        m_tdata_next    = m_tdata_reg;
        m_tuser_next    = m_tuser_reg;

        unique case (state_reg)
            ST_IDLE: begin
                if (s_tvalid) begin
                    res_drive_next = DRV_NONE;
                    res_freq_next  = '0;
                    res_acc_next   = 1'b0;
                    now_next       = in_now;
                    state_next     = ST_OUT;
                    priority if (in_req == REQ_ADD) begin
                        if (ram_we) begin
                            step_count_next = step_count_reg + 1'b1;
                            res_acc_next    = 1'b1;
                        end
                    end else if (in_req == REQ_CLEAR) begin
                        step_count_next = '0;
                        play_index_next = '0;
                        started_next    = 1'b0;
                        start_time_next = '0;
                        res_drive_next  = DRV_SILENCE;
                    end else if (in_req == REQ_UPDATE) begin
                        if (play_index_reg >= step_count_reg) begin
                            if (step_count_reg != '0) begin
                                res_drive_next  = DRV_SILENCE;
                                step_count_next = '0;
                                play_index_next = '0;
                            end
                            started_next = 1'b0;
                        end else begin
                            state_next = ST_READ;
                        end
                    end else begin
                        state_next = ST_OUT;
                    end
                end
            end
            ST_READ: begin
                state_next = ST_OUT;
                if (!started_reg) begin
                    if (rd_step.start_freq == '0) begin
                        res_drive_next = DRV_SILENCE;
                    end else begin
                        res_drive_next = DRV_TONE;
                        res_freq_next  = rd_step.start_freq;
                    end
                    started_next    = 1'b1;
                    start_time_next = now_reg;
                end else if (elapsed >= TIME_W'(rd_step.duration_ms)) begin
                    play_index_next = play_index_reg + 1'b1;
                    started_next    = 1'b0;
                end else if (rd_step.start_freq != rd_step.end_freq
                             && rd_step.start_freq != '0) begin
                    up_next      = (rd_step.end_freq >= rd_step.start_freq);
                    span_next    = (rd_step.end_freq >= rd_step.start_freq)
                                   ? rd_step.end_freq - rd_step.start_freq
                                   : rd_step.start_freq - rd_step.end_freq;
                    base_next    = rd_step.start_freq;
                    elapsed_next = elapsed[DUR_W-1:0];
                    dur_next     = rd_step.duration_ms;
                    state_next   = ST_MUL;
                end
            end
            ST_MUL: begin
                // product >> FREQ_W is below the divisor, so 15 quotient bits remain
                rem_next     = product[PROD_W-1:FREQ_W];
                lo_next      = product[FREQ_W-1:0];
                quo_next     = '0;
                bit_cnt_next = 4'(FREQ_W - 1);
                state_next   = ST_DIV;
            end
            ST_DIV: begin
                rem_next     = trial_ge ? DUR_W'(trial - {1'b0, dur_reg}) : trial[DUR_W-1:0];
                lo_next      = {lo_reg[FREQ_W-2:0], 1'b0};
                quo_next     = {quo_reg[FREQ_W-2:0], trial_ge};
                bit_cnt_next = bit_cnt_reg - 1'b1;
                if (bit_cnt_reg == '0) begin
                    res_drive_next = DRV_TONE;
                    res_freq_next  = up_reg ? base_reg + {quo_reg[FREQ_W-2:0], trial_ge}
                                            : base_reg - {quo_reg[FREQ_W-2:0], trial_ge};
                    state_next     = ST_OUT;
                end
            end
            ST_OUT: begin
                if (out_free) begin
                    m_tvalid_next = 1'b1;
                    m_tuser_next  = res_drive_reg;
                    m_tdata_next  = M_TDATA_W'({(play_index_reg < step_count_reg),
                                                res_acc_reg, res_freq_reg});
                    state_next    = ST_IDLE;
                end
            end
            default: begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg      <= ST_IDLE;
            step_count_reg <= '0;
            play_index_reg <= '0;
            started_reg    <= 1'b0;
            start_time_reg <= '0;
            m_tvalid_reg   <= 1'b0;
        end else begin
            state_reg      <= state_next;
            step_count_reg <= step_count_next;
            play_index_reg <= play_index_next;
            started_reg    <= started_next;
            start_time_reg <= start_time_next;
            m_tvalid_reg   <= m_tvalid_next;
        end
    end

    always_ff @(posedge aclk) begin
        now_reg       <= now_next;
        res_drive_reg <= res_drive_next;
        res_freq_reg  <= res_freq_next;
        res_acc_reg   <= res_acc_next;
        base_reg      <= base_next;
        span_reg      <= span_next;
        up_reg        <= up_next;
        elapsed_reg   <= elapsed_next;
        dur_reg       <= dur_next;
        rem_reg       <= rem_next;
        lo_reg        <= lo_next;
        quo_reg       <= quo_next;
        bit_cnt_reg   <= bit_cnt_next;
        m_tdata_reg   <= m_tdata_next;
        m_tuser_reg   <= m_tuser_next;
    end

    assign m_tvalid = m_tvalid_reg;
    assign m_tdata  = m_tdata_reg;
    assign m_tuser  = m_tuser_reg;

    a_index_in_queue: assert property (@(posedge aclk) disable iff (!aresetn)
        play_index_reg <= step_count_reg)
        else $error("play index beyond step count");

    a_count_bound: assert property (@(posedge aclk) disable iff (!aresetn)
        step_count_reg <= CNT_W'(QUEUE_DEPTH))
        else $error("step count beyond queue depth");

    a_div_nonzero: assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg == ST_DIV) |-> (dur_reg != '0))
        else $error("divide by zero duration");

    a_one_in_flight: assert property (@(posedge aclk) disable iff (!aresetn)
        (s_tvalid && s_tready) |=> !s_tready)
        else $error("second word taken while one is in flight");

endmodule

`default_nettype wire
